// ===== hdl/tws_pkg.sv =====
// shared types and constants for the two-wire sensor slave
`timescale 1ns / 1ps

package tws_pkg;

   localparam int WORD_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int BIT_CNT_WIDTH   = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HUMIDITY    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TEMPERATURE = 2'd1;

   localparam logic [WORD_WIDTH-1:0] CMD_HUMIDITY    = 16'd5;
   localparam logic [WORD_WIDTH-1:0] CMD_TEMPERATURE = 16'd3;

   localparam logic [BIT_CNT_WIDTH-1:0] BIT_FIRST = 3'd0;
   localparam logic [BIT_CNT_WIDTH-1:0] BIT_LAST  = 3'd7;

   // protocol phases, one-hot
   typedef enum logic [9:0] {
      PH_IDLE     = 10'b00_0000_0001,
      PH_START    = 10'b00_0000_0010,
      PH_READ     = 10'b00_0000_0100,
      PH_ACK      = 10'b00_0000_1000,
      PH_ACK_DONE = 10'b00_0001_0000,
      PH_WR_LO    = 10'b00_0010_0000,
      PH_WR7_DONE = 10'b00_0100_0000,
      PH_WAIT_ACK = 10'b00_1000_0000,
      PH_WR_HI    = 10'b01_0000_0000,
      PH_DONE     = 10'b10_0000_0000
   } phase_type;

   // one response
   typedef struct packed {
      logic pull_data_low;
      logic in_transfer;
      logic no_ack_abort;
   } rsp_type;

endpackage

// ===== hdl/two_wire_sensor_slave.sv =====
// top level of the two-wire sensor slave: line decoder, phase machine and response buffer
`timescale 1ns / 1ps

// a response is registered into the head entry, or into the skid entry while the head is stalled
// throughput: one request per cycle while req_ready is high; the phase machine updates once per request
// a two-entry response buffer keeps req_ready high while one response waits
// reset (synchronous, active high): idle phase, lines seen high, line released,
// both sensor words zero, response buffer empty

module two_wire_sensor_slave
   import tws_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // sampled line levels
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_clock_line,
   input  logic                       req_data_line,
   // per-sample response
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_pull_data_low,
   output logic                       rsp_in_transfer,
   output logic                       rsp_no_ack_abort,
   // register writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]      csr_wdata
);

   // sensor words
   logic [WORD_WIDTH-1:0] humidity_ff, humidity_in;
   logic [WORD_WIDTH-1:0] temperature_ff, temperature_in;

   // protocol state
   phase_type              phase_ff, phase_in;
   logic [BIT_CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic [WORD_WIDTH-1:0]  shift_ff, shift_in;
   logic                   prev_clock_ff, prev_clock_in;
   logic                   prev_data_ff, prev_data_in;
   logic                   drive_low_ff, drive_low_in;

   // response buffer: head plus one skid entry
   rsp_type head_ff, head_in;
   rsp_type skid_ff, skid_in;
   logic    head_valid_ff, head_valid_in;
   logic    skid_valid_ff, skid_valid_in;

   logic    req_fire;
   logic    rsp_fire;
   logic    abort;
   rsp_type rsp_new;

   logic clk_rise, clk_fall, dat_rise, dat_fall;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = head_valid_ff;
   assign rsp_fire  = head_valid_ff && rsp_ready;

   assign rsp_pull_data_low = head_ff.pull_data_low;
   assign rsp_in_transfer   = head_ff.in_transfer;
   assign rsp_no_ack_abort  = head_ff.no_ack_abort;

   // register writes, unknown indexes dropped
   always_comb begin
      humidity_in    = humidity_ff;
      temperature_in = temperature_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HUMIDITY:    humidity_in    = csr_wdata;
            CSR_TEMPERATURE: temperature_in = csr_wdata;
            default:         ;
         endcase
      end
   end

   // edges against the previous sample
   assign clk_rise = !prev_clock_ff &&  req_clock_line;
   assign clk_fall =  prev_clock_ff && !req_clock_line;
   assign dat_rise = !prev_data_ff  &&  req_data_line;
   assign dat_fall =  prev_data_ff  && !req_data_line;

   // phase machine, advanced once per accepted sample
   always_comb begin
      phase_in      = phase_ff;
      bit_cnt_in    = bit_cnt_ff;
      shift_in      = shift_ff;
      drive_low_in  = drive_low_ff;
      prev_clock_in = prev_clock_ff;
      prev_data_in  = prev_data_ff;
      abort         = 1'b0;

      if (req_fire) begin
         prev_clock_in = req_clock_line;
         prev_data_in  = req_data_line;
         case (phase_ff)
            PH_IDLE: begin
               // start condition part one: data falls with clock high
               if (dat_fall && req_clock_line) begin
                  phase_in     = PH_START;
                  drive_low_in = 1'b0;
               end
            end
            PH_START: begin
               if (dat_rise) begin
                  if (req_clock_line) begin
                     phase_in   = PH_READ;
                     bit_cnt_in = BIT_FIRST;
                  end else begin
                     phase_in     = PH_IDLE;
                     drive_low_in = 1'b0;
                  end
               end
            end
            PH_READ: begin
               // command bits, msb first, on clock rise
               if (clk_rise) begin
                  if (bit_cnt_ff == BIT_FIRST) begin
                     shift_in = {{(WORD_WIDTH-1){1'b0}}, req_data_line};
                  end else begin
                     shift_in = {shift_ff[WORD_WIDTH-2:0], req_data_line};
                  end
                  if (bit_cnt_ff == BIT_LAST) begin
                     phase_in = PH_ACK;
                  end else begin
                     bit_cnt_in = bit_cnt_ff + 3'd1;
                  end
               end
            end
            PH_ACK: begin
               if (clk_fall) begin
                  drive_low_in = 1'b1;
                  phase_in     = PH_ACK_DONE;
               end
            end
            PH_ACK_DONE: begin
               // release ack and decode the command
               if (clk_fall) begin
                  drive_low_in = 1'b0;
                  bit_cnt_in   = BIT_FIRST;
                  if (shift_ff == CMD_HUMIDITY) begin
                     shift_in = humidity_ff;
                     phase_in = PH_WR_LO;
                  end else if (shift_ff == CMD_TEMPERATURE) begin
                     shift_in = temperature_ff;
                     phase_in = PH_WR_LO;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_WR_LO, PH_WR_HI: begin
               // word bits msb first on clock fall, open drain
               if (clk_fall) begin
                  drive_low_in = !shift_ff[WORD_WIDTH-1];
                  shift_in     = {shift_ff[WORD_WIDTH-2:0], 1'b0};
                  if (bit_cnt_ff == BIT_LAST) begin
                     phase_in = (phase_ff == PH_WR_LO) ? PH_WR7_DONE : PH_DONE;
                  end else begin
                     bit_cnt_in = bit_cnt_ff + 3'd1;
                  end
               end
            end
            PH_WR7_DONE: begin
               if (clk_fall) begin
                  drive_low_in = 1'b0;
                  phase_in     = PH_WAIT_ACK;
               end
            end
            PH_WAIT_ACK: begin
               // master ack sampled on clock rise; high means no ack
               if (clk_rise) begin
                  drive_low_in = 1'b0;
                  if (req_data_line) begin
                     phase_in = PH_IDLE;
                     abort    = 1'b1;
                  end else begin
                     phase_in   = PH_WR_HI;
                     bit_cnt_in = BIT_FIRST;
                  end
               end
            end
            PH_DONE: begin
               if (clk_fall) begin
                  phase_in     = PH_IDLE;
                  drive_low_in = 1'b0;
               end
            end
            default: begin
               phase_in     = PH_IDLE;
               drive_low_in = 1'b0;
            end
         endcase
      end
   end

   assign rsp_new.pull_data_low = drive_low_in;
   assign rsp_new.in_transfer   = (phase_in != PH_IDLE);
   assign rsp_new.no_ack_abort  = abort;

   // response buffer; a push never meets a full skid entry
   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_fire) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = req_fire;
            head_in       = rsp_new;
         end
      end else if (req_fire) begin
         if (head_valid_ff) begin
            skid_in       = rsp_new;
            skid_valid_in = 1'b1;
         end else begin
            head_in       = rsp_new;
            head_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         humidity_ff    <= '0;
         temperature_ff <= '0;
         phase_ff       <= PH_IDLE;
         bit_cnt_ff     <= BIT_FIRST;
         shift_ff       <= '0;
         prev_clock_ff  <= 1'b1;
         prev_data_ff   <= 1'b1;
         drive_low_ff   <= 1'b0;
         head_valid_ff  <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         humidity_ff    <= humidity_in;
         temperature_ff <= temperature_in;
         phase_ff       <= phase_in;
         bit_cnt_ff     <= bit_cnt_in;
         shift_ff       <= shift_in;
         prev_clock_ff  <= prev_clock_in;
         prev_data_ff   <= prev_data_in;
         drive_low_ff   <= drive_low_in;
         head_valid_ff  <= head_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== hdl/tws_checker.sv =====
// port-level checks for the two-wire sensor slave and their bind
`timescale 1ns / 1ps

module tws_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_pull_data_low,
   input logic rsp_in_transfer,
   input logic rsp_no_ack_abort
);

   // buffer is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // an abort always lands in idle
   a_abort_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_ack_abort |-> !rsp_in_transfer)
      else $error("no-ack abort while still in transfer");

   // the line is released whenever idle
   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_transfer |-> !rsp_pull_data_low)
      else $error("data pulled low while idle");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pull_data_low)
         && $stable(rsp_in_transfer) && $stable(rsp_no_ack_abort))
      else $error("stalled response changed");

endmodule

bind two_wire_sensor_slave tws_checker u_tws_checker (.*);

// ===== test/two_wire_sensor_slave_tb.sv =====
// testbench for the two-wire sensor slave: line-level master traffic checked against a predictor
`timescale 1ns / 1ps

module two_wire_sensor_slave_tb;
   import tws_pkg::*;

   localparam int RANDOM_ITEMS  = 900;
   localparam int RANDOM_PHASES = 6;
   localparam int WHOLE_SEQ     = 1 << 30;
   localparam int RUN_LIMIT_NS  = 5_000_000;

   // register indexes past the two sensor words are not decoded
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic clk_level;
      logic data_level;
   } line_sample_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_clock_line = 1'b1;
   logic                       req_data_line = 1'b1;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b1;
   logic                       rsp_pull_data_low;
   logic                       rsp_in_transfer;
   logic                       rsp_no_ack_abort;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [WORD_WIDTH-1:0]      csr_wdata = '0;

   two_wire_sensor_slave dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_clock_line    (req_clock_line),
      .req_data_line     (req_data_line),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pull_data_low (rsp_pull_data_low),
      .rsp_in_transfer   (rsp_in_transfer),
      .rsp_no_ack_abort  (rsp_no_ack_abort),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // line samples waiting to go out, and the pin responses they should cause
   line_sample_type line_samples[$];
   rsp_type         expected_pins[$];
   line_sample_type head_sample;

   int samples_queued = 0;
   int responses_seen = 0;
   int fail_count     = 0;
   int cut_left       = WHOLE_SEQ;
   int send_gap       = 0;
   int stall_left     = 0;
   bit calm           = 1'b0;
   bit req_fired      = 1'b0;

   // slave state as the testbench sees it
   phase_type                slave_phase;
   logic [BIT_CNT_WIDTH-1:0] slave_bit;
   logic [WORD_WIDTH-1:0]    slave_shift;
   logic                     slave_pull;
   logic                     last_clock;
   logic                     last_data;
   logic [WORD_WIDTH-1:0]    hum_word;
   logic [WORD_WIDTH-1:0]    temp_word;

   function automatic logic rand_bit();
      rand_bit = 1'($urandom_range(0, 1));
   endfunction

   // advance the slave by one line sample and return the pin levels after it
   function automatic rsp_type next_line_response(input logic clk, input logic dat);
      logic    clk_rise;
      logic    clk_fall;
      logic    dat_rise;
      logic    dat_fall;
      rsp_type pins;
      clk_rise = !last_clock && clk;
      clk_fall = last_clock && !clk;
      dat_rise = !last_data && dat;
      dat_fall = last_data && !dat;
      pins.no_ack_abort = 1'b0;
      case (slave_phase)
         PH_IDLE: begin
            if (dat_fall && clk) begin
               slave_phase = PH_START;
               slave_pull  = 1'b0;
            end
         end
         PH_START: begin
            if (dat_rise) begin
               if (clk) begin
                  slave_phase = PH_READ;
                  slave_bit   = BIT_FIRST;
               end else begin
                  slave_phase = PH_IDLE;
                  slave_pull  = 1'b0;
               end
            end
         end
         PH_READ: begin
            if (clk_rise) begin
               if (slave_bit == BIT_FIRST)
                  slave_shift = '0;
               slave_shift = {slave_shift[WORD_WIDTH-2:0], dat};
               if (slave_bit == BIT_LAST)
                  slave_phase = PH_ACK;
               else
                  slave_bit = slave_bit + 3'd1;
            end
         end
         PH_ACK: begin
            if (clk_fall) begin
               slave_pull  = 1'b1;
               slave_phase = PH_ACK_DONE;
            end
         end
         PH_ACK_DONE: begin
            if (clk_fall) begin
               slave_pull = 1'b0;
               slave_bit  = BIT_FIRST;
               if (slave_shift == CMD_HUMIDITY) begin
                  slave_shift = hum_word;
                  slave_phase = PH_WR_LO;
               end else if (slave_shift == CMD_TEMPERATURE) begin
                  slave_shift = temp_word;
                  slave_phase = PH_WR_LO;
               end else begin
                  slave_phase = PH_IDLE;
               end
            end
         end
         PH_WR_LO, PH_WR_HI: begin
            if (clk_fall) begin
               slave_pull  = !slave_shift[WORD_WIDTH-1];
               slave_shift = slave_shift << 1;
               if (slave_bit == BIT_LAST)
                  slave_phase = (slave_phase == PH_WR_LO) ? PH_WR7_DONE : PH_DONE;
               else
                  slave_bit = slave_bit + 3'd1;
            end
         end
         PH_WR7_DONE: begin
            if (clk_fall) begin
               slave_pull  = 1'b0;
               slave_phase = PH_WAIT_ACK;
            end
         end
         PH_WAIT_ACK: begin
            if (clk_rise) begin
               slave_pull = 1'b0;
               if (dat) begin
                  slave_phase       = PH_IDLE;
                  pins.no_ack_abort = 1'b1;
               end else begin
                  slave_phase = PH_WR_HI;
                  slave_bit   = BIT_FIRST;
               end
            end
         end
         PH_DONE: begin
            if (clk_fall) begin
               slave_phase = PH_IDLE;
               slave_pull  = 1'b0;
            end
         end
         default: begin
            slave_phase = PH_IDLE;
            slave_pull  = 1'b0;
         end
      endcase
      last_clock         = clk;
      last_data          = dat;
      pins.pull_data_low = slave_pull;
      pins.in_transfer   = (slave_phase != PH_IDLE);
      return pins;
   endfunction

   task automatic note_mismatch(input string field, input logic want, input logic got);
      fail_count++;
      $display("%0t: %s expected %b actual %b", $time, field, want, got);
   endtask

   // ---------------------------------------------------------------------
   // monitor: register writes, response check, prediction per request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         slave_phase = PH_IDLE;
         slave_bit   = BIT_FIRST;
         slave_shift = '0;
         slave_pull  = 1'b0;
         last_clock  = 1'b1;
         last_data   = 1'b1;
         hum_word    = '0;
         temp_word   = '0;
         req_fired   = 1'b0;
      end else begin
         req_fired = req_valid && req_ready;

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HUMIDITY:    hum_word = csr_wdata;
               CSR_TEMPERATURE: temp_word = csr_wdata;
               default: ;
            endcase
         end

         // responses are registered after their request is accepted, so check first
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            if (expected_pins.size() == 0) begin
               fail_count++;
               $display("%0t: response expected none actual %b%b%b", $time,
                        rsp_pull_data_low, rsp_in_transfer, rsp_no_ack_abort);
            end else begin
               rsp_type want;
               want = expected_pins.pop_front();
               if (rsp_pull_data_low !== want.pull_data_low)
                  note_mismatch("pull_data_low", want.pull_data_low, rsp_pull_data_low);
               if (rsp_in_transfer !== want.in_transfer)
                  note_mismatch("in_transfer", want.in_transfer, rsp_in_transfer);
               if (rsp_no_ack_abort !== want.no_ack_abort)
                  note_mismatch("no_ack_abort", want.no_ack_abort, rsp_no_ack_abort);
            end
         end

         if (req_fired)
            expected_pins.push_back(next_line_response(req_clock_line, req_data_line));
      end
   end

   // ---------------------------------------------------------------------
   // request driver: one line sample per request, random gaps between
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fired)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (line_samples.size() > 0) begin
            head_sample = line_samples.pop_front();
            req_valid      <= 1'b1;
            req_clock_line <= head_sample.clk_level;
            req_data_line  <= head_sample.data_level;
            if (!calm && $urandom_range(0, 11) == 0)
               send_gap = $urandom_range(1, 14);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side back-pressure in bursts, started only outside the calm phase
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // queue one line sample, sometimes held for an extra request;
   // cut_left truncates a sequence to model a master that gives up
   task automatic put_sample(input logic c, input logic d);
      line_sample_type s;
      s.clk_level  = c;
      s.data_level = d;
      if (cut_left == 0)
         return;
      cut_left--;
      line_samples.push_back(s);
      samples_queued++;
      if ($urandom_range(0, 7) == 0) begin
         line_samples.push_back(s);
         samples_queued++;
      end
   endtask

   // one master read: start, command byte, slave ack, sensor data bytes, second on master ack
   task automatic master_read(input logic [7:0] cmd, input logic ack_level);
      int lead;
      lead = $urandom_range(1, 3);
      repeat (lead) put_sample(1'b1, 1'b1);
      // data falls with clock high, optional clock pulse, data rises with clock high
      put_sample(1'b1, 1'b0);
      if (rand_bit()) begin
         put_sample(1'b0, 1'b0);
         put_sample(1'b1, 1'b0);
      end
      put_sample(1'b1, 1'b1);
      // command bits taken on clock rises, msb first
      for (int i = 7; i >= 0; i--) begin
         put_sample(1'b0, ($urandom_range(0, 3) == 0) ? rand_bit() : cmd[i]);
         put_sample(1'b1, cmd[i]);
      end
      // slave ack window: the clock falls that drive and release the ack
      put_sample(1'b0, rand_bit());
      put_sample(1'b1, rand_bit());
      put_sample(1'b0, rand_bit());
      if ({8'h00, cmd} == CMD_HUMIDITY || {8'h00, cmd} == CMD_TEMPERATURE) begin
         // first byte plus the gap pulse
         repeat (9) begin
            put_sample(1'b1, rand_bit());
            put_sample(1'b0, rand_bit());
         end
         // master ack on the clock rise
         put_sample(1'b1, ack_level);
         if (!ack_level) begin
            put_sample(1'b0, rand_bit());
            repeat (8) begin
               put_sample(1'b1, rand_bit());
               put_sample(1'b0, rand_bit());
            end
         end else begin
            put_sample(1'b0, 1'b1);
         end
      end
      put_sample(1'b1, 1'b1);
   endtask

   task automatic line_noise(input int count);
      repeat (count) put_sample(rand_bit(), rand_bit());
   endtask

   // clock pulses with data high walk every phase back to idle
   task automatic bring_to_idle();
      repeat (20) begin
         put_sample(1'b0, 1'b1);
         put_sample(1'b1, 1'b1);
      end
   endtask

   task automatic random_traffic();
      int          pick;
      int          kind;
      logic [7:0]  cmd;
      logic        ack_level;
      pick = $urandom_range(0, 99);
      kind = $urandom_range(0, 9);
      if (kind < 4)
         cmd = CMD_HUMIDITY[7:0];
      else if (kind < 8)
         cmd = CMD_TEMPERATURE[7:0];
      else
         cmd = 8'($urandom_range(0, 255));
      ack_level = ($urandom_range(0, 6) == 0);
      if (pick < 72) begin
         master_read(cmd, ack_level);
      end else if (pick < 86) begin
         // master abandons the read partway through
         cut_left = $urandom_range(2, 60);
         master_read(cmd, ack_level);
         cut_left = WHOLE_SEQ;
         bring_to_idle();
      end else begin
         line_noise($urandom_range(1, 30));
         bring_to_idle();
      end
   endtask

   // let every request come back before returning
   task automatic wait_until_quiet();
      while (responses_seen < samples_queued) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // csr_valid stays up across back-to-back writes and is lowered by the caller
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [WORD_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_sensor_words(input logic [WORD_WIDTH-1:0] hum,
                                    input logic [WORD_WIDTH-1:0] temp);
      write_reg(CSR_HUMIDITY, hum);
      write_reg(CSR_TEMPERATURE, temp);
      write_reg(CSR_SPARE_A, WORD_WIDTH'($urandom));
      write_reg(CSR_SPARE_B, WORD_WIDTH'($urandom));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      int target;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_sensor_words(16'hFFFF, 16'h0000);

      // data falls while clock is low: no start
      put_sample(1'b1, 1'b1);
      put_sample(1'b0, 1'b1);
      put_sample(1'b0, 1'b0);
      put_sample(1'b1, 1'b0);
      put_sample(1'b1, 1'b1);
      // start, then data rises while clock is low: back to idle
      put_sample(1'b1, 1'b0);
      put_sample(1'b0, 1'b0);
      put_sample(1'b0, 1'b1);
      put_sample(1'b1, 1'b1);
      // unknown command, humidity all ones, temperature with missing master ack
      master_read(8'hFF, 1'b0);
      master_read(CMD_HUMIDITY[7:0], 1'b0);
      master_read(CMD_TEMPERATURE[7:0], 1'b1);

      for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
         // sender holds off here until every response is back
         wait_until_quiet();
         case (ph)
            1:       load_sensor_words(16'h0000, 16'hFFFF);
            2:       load_sensor_words(16'h8000, 16'h0001);
            3:       load_sensor_words(16'hAAAA, 16'h5555);
            default: load_sensor_words(WORD_WIDTH'($urandom), WORD_WIDTH'($urandom));
         endcase
         // last phase starts no new gaps and no new stalls
         if (ph == RANDOM_PHASES)
            calm = 1'b1;
         target = samples_queued + RANDOM_ITEMS / RANDOM_PHASES;
         while (samples_queued < target)
            random_traffic();
      end

      wait_until_quiet();
      if (expected_pins.size() != 0) begin
         fail_count++;
         $display("%0t: %0d responses never arrived", $time, expected_pins.size());
      end
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/tws_pkg.sv
hdl/two_wire_sensor_slave.sv
hdl/tws_checker.sv
test/two_wire_sensor_slave_tb.sv
